/* sv/lpsh_pkg.sv */
`timescale 1ns / 1ps
package lpsh_pkg;

  localparam int RADIAL_BINS = 5;
  localparam int ANGLE_BINS  = 12;
  localparam int NUM_BINS    = ANGLE_BINS * RADIAL_BINS;
  localparam int BIN_W       = 6;
  localparam int COORD_W     = 16;
  localparam int MDS_W       = 33;
  localparam int INNER_SHIFT = 6;
  localparam int COUNT_W     = 9;
  localparam int FRAC_W      = 17;
  localparam logic [MDS_W-1:0] MDS_RESET = 33'd256;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_DRAIN,
    ST_BIN_RD,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } lpsh_state_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [FRAC_W-1:0]  bin_fraction;
    logic               last_bin;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] idx;
  } bin_upd_t;

endpackage

/* sv/lpsh_ram.sv */
`timescale 1ns / 1ps
module lpsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/lpsh_binner.sv */
`timescale 1ns / 1ps
module lpsh_binner import lpsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  input  logic signed [COORD_W-1:0] rx,
  input  logic signed [COORD_W-1:0] ry,
  input  logic [MDS_W-1:0]          mean_dist_sq,
  output bin_upd_t                  upd,
  output logic                      busy
);

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int LHS_W  = D2_W + INNER_SHIFT;
  localparam int RHS_W  = MDS_W + 2 * (RADIAL_BINS - 1);

  logic                     v1_r, v2_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [1:0]               quad_r;
  logic                     zero_r;
  bin_upd_t                 upd_r;

  logic [DIFF_W-1:0]  ax17, ay17;
  logic [COORD_W-1:0] ax, ay;
  logic               dx_pos, dy_pos, dx_neg, dy_neg;
  logic [1:0]         quad_nxt;
  logic [SQ_W-1:0]    uu, vv;
  logic [SQ_W+1:0]    uu3, vv3;
  logic [D2_W-1:0]    d2;
  logic [RHS_W-1:0]   lhs;
  logic [RADIAL_BINS-1:0] under;
  logic [2:0]         n;
  logic [3:0]         sec;
  logic [6:0]         idx7;

  always_comb begin
    ax17 = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    ay17 = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    ax = ax17[COORD_W-1:0];
    ay = ay17[COORD_W-1:0];
    dx_neg = dx_r[DIFF_W-1];
    dy_neg = dy_r[DIFF_W-1];
    dx_pos = !dx_neg && (dx_r != '0);
    dy_pos = !dy_neg && (dy_r != '0);
    if (dx_pos && !dy_neg) begin
      quad_nxt = 2'd0;
    end else if (!dx_pos && dy_pos) begin
      quad_nxt = 2'd1;
    end else if (dx_neg && !dy_pos) begin
      quad_nxt = 2'd2;
    end else begin
      quad_nxt = 2'd3;
    end
  end

  always_comb begin
    uu  = quad_r[0] ? sqy_r : sqx_r;
    vv  = quad_r[0] ? sqx_r : sqy_r;
    uu3 = {1'b0, uu, 1'b0} + {2'b00, uu};
    vv3 = {1'b0, vv, 1'b0} + {2'b00, vv};
    d2  = {1'b0, sqx_r} + {1'b0, sqy_r};
    lhs = RHS_W'({d2, {INNER_SHIFT{1'b0}}});
    for (int i = 0; i < RADIAL_BINS; i++) begin
      under[i] = lhs < (RHS_W'(mean_dist_sq) << (2 * i));
    end
    n = 3'($countones(under));
    sec = 4'({2'b00, quad_r} * 4'd3) + 4'(vv3 >= {2'b00, uu}) + 4'(uu3 <= {2'b00, vv});
    if (zero_r) begin
      sec = 4'd0;
    end
    if (sec > 4'(ANGLE_BINS - 1)) begin
      sec = 4'(ANGLE_BINS - 1);
    end
    idx7 = 7'(sec) * 7'(RADIAL_BINS) + 7'(n) - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      upd_r.valid <= 1'b0;
    end else begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      upd_r.valid <= v2_r && (n != 3'd0) && (idx7 < 7'(NUM_BINS));
    end
    dx_r   <= {qx[COORD_W-1], qx} - {rx[COORD_W-1], rx};
    dy_r   <= {qy[COORD_W-1], qy} - {ry[COORD_W-1], ry};
    sqx_r  <= ax * ax;
    sqy_r  <= ay * ay;
    quad_r <= quad_nxt;
    zero_r <= (dy_r == '0) && !dx_neg;
    upd_r.idx <= idx7[BIN_W-1:0];
  end

  assign upd  = upd_r;
  assign busy = v1_r || v2_r || upd_r.valid;

endmodule

/* sv/lpsh_divider.sv */
`timescale 1ns / 1ps
module lpsh_divider import lpsh_pkg::*; #(
  parameter int CW = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CW-1:0]     num,
  input  logic [CW-1:0]     den,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  localparam int STEP_W = $clog2(FRAC_W);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [CW:0]       rem_r;
  logic [CW-1:0]     den_r;
  logic [FRAC_W-1:0] quot_r;

  logic          ge;
  logic [CW:0]   rsub;

  always_comb begin
    ge   = rem_r >= {1'b0, den_r};
    rsub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(FRAC_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= {rsub[CW-1:0], 1'b0};
      quot_r <= {quot_r[FRAC_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* sv/log_polar_shape_histogram.sv */
`timescale 1ns / 1ps
// A query runs a zeroing sweep of the bin memory, a read-modify-write of the bin memory per
// reference that lands in a bin, and the 17-step serial divider per bin. One item is in
// work at a time.
// Synchronous active-low reset clears the control state and the reference count and
// sets mean_dist_sq to 256; the contents of the reference store are undefined until written.
module log_polar_shape_histogram import lpsh_pkg::*; #(
  parameter int MAX_REFS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [MDS_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int AW = MAX_REFS > 1 ? $clog2(MAX_REFS) : 1;
  localparam int REF_W = 2 * COORD_W;

  lpsh_state_t state_r, state_nxt;

  logic [MDS_W-1:0]          mds_r;
  logic [CW-1:0]             total_r;
  logic [CW-1:0]             walk_r;
  logic [BIN_W-1:0]          bin_r;
  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic                      a_valid_r;
  logic                      e_valid_r;
  logic [BIN_W-1:0]          e_idx_r;
  logic                      last_we_r;
  logic [BIN_W-1:0]          last_idx_r;
  logic [CW-1:0]             last_val_r;
  logic [CW-1:0]             cnt_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic              in_take, ref_we, ref_re;
  logic [REF_W-1:0]  ref_rdata;
  logic              bin_we, bin_re;
  logic [BIN_W-1:0]  bin_waddr, bin_raddr;
  logic [CW-1:0]     bin_wdata, bin_rdata, bin_base;
  logic              div_start, div_done, out_load;
  logic [FRAC_W-1:0] div_quot;
  bin_upd_t          upd;
  logic              binner_busy;

  assign in_take = in_valid && !in_stall;
  assign ref_we  = in_take && (in_data.mode == MODE_ADD) && (total_r < CW'(MAX_REFS));

  lpsh_ram #(.WIDTH(REF_W), .DEPTH(MAX_REFS)) u_ref_ram (
    .clk     (clk),
    .wr_en   (ref_we),
    .wr_addr (total_r[AW-1:0]),
    .wr_data ({in_data.x_coord, in_data.y_coord}),
    .rd_en   (ref_re),
    .rd_addr (walk_r[AW-1:0]),
    .rd_data (ref_rdata)
  );

  lpsh_binner u_binner (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (a_valid_r),
    .qx           (qx_r),
    .qy           (qy_r),
    .rx           (ref_rdata[REF_W-1:COORD_W]),
    .ry           (ref_rdata[COORD_W-1:0]),
    .mean_dist_sq (mds_r),
    .upd          (upd),
    .busy         (binner_busy)
  );

  lpsh_ram #(.WIDTH(CW), .DEPTH(NUM_BINS)) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_we),
    .wr_addr (bin_waddr),
    .wr_data (bin_wdata),
    .rd_en   (bin_re),
    .rd_addr (bin_raddr),
    .rd_data (bin_rdata)
  );

  lpsh_divider #(.CW(CW)) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (bin_rdata),
    .den   (total_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.mode == MODE_QUERY) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (bin_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = (total_r == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_r == total_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!a_valid_r && !binner_busy && !e_valid_r) begin
          state_nxt = ST_BIN_RD;
        end
      end
      ST_BIN_RD:   state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = (bin_r == BIN_W'(NUM_BINS - 1)) ? ST_IDLE : ST_BIN_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != ST_IDLE;
    ref_re    = state_r == ST_WALK;
    div_start = state_r == ST_DIV_LOAD;
    out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    bin_base  = (last_we_r && last_idx_r == e_idx_r) ? last_val_r : bin_rdata;
    bin_we    = 1'b0;
    bin_waddr = e_idx_r;
    bin_wdata = bin_base + CW'(1);
    bin_re    = 1'b0;
    bin_raddr = upd.idx;
    case (state_r)
      ST_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = bin_r;
        bin_wdata = '0;
      end
      ST_BIN_RD: begin
        bin_re    = 1'b1;
        bin_raddr = bin_r;
      end
      default: begin
        bin_we = e_valid_r;
        bin_re = upd.valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mds_r       <= MDS_RESET;
      total_r     <= '0;
      a_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      last_we_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      a_valid_r <= ref_re;
      e_valid_r <= upd.valid;
      last_we_r <= bin_we && (state_r != ST_CLEAR);
      if (cfg_we) begin
        mds_r <= cfg_wdata;
      end
      if (in_take && in_data.mode == MODE_CLEAR) begin
        total_r <= '0;
      end else if (ref_we) begin
        total_r <= total_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    last_idx_r <= e_idx_r;
    last_val_r <= bin_wdata;
    e_idx_r    <= upd.idx;
    if (in_take) begin
      qx_r   <= in_data.x_coord;
      qy_r   <= in_data.y_coord;
      bin_r  <= '0;
      walk_r <= '0;
    end
    if (state_r == ST_CLEAR) begin
      bin_r <= (bin_r == BIN_W'(NUM_BINS - 1)) ? '0 : bin_r + BIN_W'(1);
    end
    if (state_r == ST_WALK) begin
      walk_r <= walk_r + CW'(1);
    end
    if (state_r == ST_DIV_LOAD) begin
      cnt_r <= bin_rdata;
    end
    if (out_load) begin
      out_data_r.bin_index    <= bin_r;
      out_data_r.bin_count    <= COUNT_W'(cnt_r);
      out_data_r.bin_fraction <= (total_r == '0) ? '0 : div_quot;
      out_data_r.last_bin     <= bin_r == BIN_W'(NUM_BINS - 1);
      bin_r                   <= bin_r + BIN_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/lpsh_checker.sv */
`timescale 1ns / 1ps
module lpsh_checker import lpsh_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_data,
  input logic             cfg_we,
  input logic [MDS_W-1:0] cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output beat changed.");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bin_index <= BIN_W'(NUM_BINS - 1))
    else $error("Bin index out of range.");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_bin == (out_data.bin_index == BIN_W'(NUM_BINS - 1)))
    else $error("Last-bin flag does not match the bin index.");

  a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bin_count == '0 |-> out_data.bin_fraction == '0)
    else $error("Empty bin shows a nonzero fraction.");

  a_busy_mid_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.bin_index < BIN_W'(NUM_BINS - 2) |=> in_stall)
    else $error("Input taken before the histogram was complete.");

endmodule

bind log_polar_shape_histogram lpsh_checker u_lpsh_checker (.*);

/* tb/sv/log_polar_shape_histogram_test.sv */
`timescale 1ns / 1ps
module log_polar_shape_histogram_test;
  import lpsh_pkg::*;

  localparam int MAX_REFS = 256;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_DIRECTED = 24;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {
    ROW_POINT,
    ROW_SETTING
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [MDS_W-1:0]          setting;
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      typed;
    logic [BIN_W-1:0]          t_bin;
    logic [COUNT_W-1:0]        t_cnt;
    logic [FRAC_W-1:0]         t_frac;
  } step_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [MDS_W-1:0] cfg_wdata;

  logic [MDS_W-1:0]          mean_dist;
  logic signed [COORD_W-1:0] ref_xs [MAX_REFS];
  logic signed [COORD_W-1:0] ref_ys [MAX_REFS];
  int                        stored_refs;
  out_item_t                 bins_due [$];
  out_item_t                 bin_head;
  step_row_t                 directed_steps [NUM_DIRECTED];

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int errors;
  int bins_checked;
  int points_accepted;
  int queries_accepted;
  int settings_written;

  log_polar_shape_histogram u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int sector_of_offset(longint dx, longint dy);
    longint u, v;
    longint unsigned uu, vv;
    int q, sec;
    if (dy == 0 && dx >= 0) return 0;
    if (dx > 0 && dy >= 0) begin
      q = 0; u = dx; v = dy;
    end else if (dx <= 0 && dy > 0) begin
      q = 1; u = dy; v = -dx;
    end else if (dx < 0 && dy <= 0) begin
      q = 2; u = -dx; v = -dy;
    end else begin
      q = 3; u = -dy; v = dx;
    end
    uu = u * u;
    vv = v * v;
    sec = 3 * q;
    if (3 * vv >= uu) sec++;
    if (vv >= 3 * uu) sec++;
    if (sec > ANGLE_BINS - 1) sec = ANGLE_BINS - 1;
    return sec;
  endfunction

  function automatic int radii_enclosing(longint dx, longint dy);
    longint unsigned d2, scaled, md;
    int n, i;
    d2 = dx * dx + dy * dy;
    scaled = d2 << INNER_SHIFT;
    md = 64'(mean_dist);
    n = 0;
    for (i = 0; i < RADIAL_BINS; i++) begin
      if (scaled < (md << (2 * i))) n++;
    end
    return n;
  endfunction

  function automatic void predict_point(in_item_t pt, bit typed, int t_bin, int t_cnt,
                                        int t_frac);
    int counts [NUM_BINS];
    longint dx, dy;
    longint unsigned frac;
    int j, b, n;
    out_item_t r;
    case (pt.mode)
      MODE_CLEAR: stored_refs = 0;
      MODE_ADD: begin
        if (stored_refs < MAX_REFS) begin
          ref_xs[stored_refs] = pt.x_coord;
          ref_ys[stored_refs] = pt.y_coord;
          stored_refs++;
        end
      end
      MODE_QUERY: begin
        for (b = 0; b < NUM_BINS; b++) counts[b] = 0;
        for (j = 0; j < stored_refs; j++) begin
          dx = longint'(pt.x_coord) - longint'(ref_xs[j]);
          dy = longint'(pt.y_coord) - longint'(ref_ys[j]);
          n = radii_enclosing(dx, dy);
          if (n > 0) counts[sector_of_offset(dx, dy) * RADIAL_BINS + n - 1]++;
        end
        for (b = 0; b < NUM_BINS; b++) begin
          frac = (stored_refs != 0) ? (longint'(counts[b]) << 16) / stored_refs : 0;
          r.bin_index = BIN_W'(b);
          r.bin_count = COUNT_W'(typed ? ((b == t_bin) ? t_cnt : 0) : counts[b]);
          r.bin_fraction = typed ? FRAC_W'((b == t_bin) ? t_frac : 0) : FRAC_W'(frac);
          r.last_bin = (b == NUM_BINS - 1);
          bins_due.insert(bins_due.size(), r);
        end
        queries_accepted++;
      end
      default: ;
    endcase
    points_accepted++;
  endfunction

  function automatic logic signed [COORD_W-1:0] near(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic void pick_idling(int stage);
    case (stage)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 85;
      end
      1: begin
        send_idle_pct = 85;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic send_point(in_item_t pt, bit typed = 0, int t_bin = 0, int t_cnt = 0,
                            int t_frac = 0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (in_stall);
    predict_point(pt, typed, t_bin, t_cnt, t_frac);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mean_dist(logic [MDS_W-1:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mean_dist = v;
    settings_written++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      if (bins_due.size() == 0) begin
        $error("bin %0d arrived with no bin outstanding", out_data.bin_index);
        errors++;
      end else begin
        bin_head = bins_due.pop_front();
        bins_checked++;
        if (out_data.bin_index !== bin_head.bin_index) begin
          $error("bin_index: expected %0d, got %0d", bin_head.bin_index, out_data.bin_index);
          errors++;
        end
        if (out_data.bin_count !== bin_head.bin_count) begin
          $error("bin_count: expected %0d, got %0d", bin_head.bin_count, out_data.bin_count);
          errors++;
        end
        if (out_data.bin_fraction !== bin_head.bin_fraction) begin
          $error("bin_fraction: expected %0d, got %0d", bin_head.bin_fraction,
                 out_data.bin_fraction);
          errors++;
        end
        if (out_data.last_bin !== bin_head.last_bin) begin
          $error("last_bin: expected %0d, got %0d", bin_head.last_bin, out_data.last_bin);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int k, ph, j, b, msb, sl, spread, cx, cy, phase_items, n_adds, n_queries;
    in_item_t pt;
    step_row_t row;
    logic [MDS_W-1:0] phase_mds [6];

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mean_dist = MDS_RESET;
    stored_refs = 0;
    cycle_count = 0;
    errors = 0;
    bins_checked = 0;
    points_accepted = 0;
    queries_accepted = 0;
    settings_written = 0;
    pick_idling(0);

    directed_steps = '{
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b1, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_UNUSED, -16'sd1,    -16'sd1,    1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_ADD,    16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b1, 6'd4, 9'd1, 17'd65536},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd1,     16'sd0,     1'b1, 6'd4, 9'd1, 17'd65536},
      '{ROW_POINT,   33'd0, MODE_QUERY,  -16'sd1,    16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd1,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     -16'sd1,    1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd1,     16'sd1,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sh7FFF,  16'sh7FFF,  1'b1, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_ADD,    16'sh8000,  16'sh8000,  1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sh7FFF,  16'sh8000,  1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_SETTING, 33'h1_FFFF_FFFF, MODE_QUERY, 16'sd0, 16'sd0, 1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sh7FFF,  16'sh7FFF,  1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sh8000,  16'sh7FFF,  1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_SETTING, 33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b1, 6'd0, 9'd0, 17'd0},
      '{ROW_SETTING, 33'd1, MODE_QUERY,  16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_CLEAR,  16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b1, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_ADD,    16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_ADD,    16'sd1,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  16'sd0,     16'sd0,     1'b0, 6'd0, 9'd0, 17'd0},
      '{ROW_POINT,   33'd0, MODE_QUERY,  -16'sd3,    -16'sd2,    1'b0, 6'd0, 9'd0, 17'd0}
    };

    phase_mds[0] = 33'd256;
    phase_mds[1] = MDS_W'($urandom_range(1 << 10, 1 << 20));
    phase_mds[2] = 33'h1_FFFF_FFFF;
    phase_mds[3] = 33'd1;
    phase_mds[4] = {1'($urandom_range(0, 1)), 32'($urandom)};
    phase_mds[5] = MDS_W'($urandom_range(4, 4096));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      row = directed_steps[k];
      if (row.kind == ROW_SETTING) begin
        write_mean_dist(row.setting);
      end else begin
        pt.mode = row.mode;
        pt.x_coord = row.x;
        pt.y_coord = row.y;
        send_point(pt, row.typed, int'(row.t_bin), int'(row.t_cnt), int'(row.t_frac));
      end
    end

    // Each sequence usually clears the store, loads a cluster of references and queries mostly near
    // it, with the spread tied to the mean distance so that the radial slots get hits.
    for (ph = 0; ph < 6; ph++) begin
      write_mean_dist(phase_mds[ph]);
      pick_idling(ph / 2);
      msb = 0;
      for (b = 0; b < MDS_W; b++) begin
        if (mean_dist[b]) msb = b;
      end
      phase_items = 0;
      while (phase_items < 4) begin
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
        sl = msb / 2 + int'($urandom_range(0, 4)) - 3;
        if (sl < 0) sl = 0;
        if (sl > 15) sl = 15;
        spread = 1 << sl;
        if ($urandom_range(0, 9) != 0) begin
          pt.mode = MODE_CLEAR;
          pt.x_coord = COORD_W'($urandom);
          pt.y_coord = COORD_W'($urandom);
          send_point(pt);
          phase_items++;
          if ($urandom_range(0, 9) == 0) begin
            pt.mode = MODE_QUERY;
            send_point(pt);
            phase_items++;
          end
        end
        n_adds = $urandom_range(1, 6);
        for (j = 0; j < n_adds; j++) begin
          if ($urandom_range(0, 15) == 0) begin
            pt.mode = MODE_UNUSED;
            pt.x_coord = COORD_W'($urandom);
            pt.y_coord = COORD_W'($urandom);
            send_point(pt);
          end
          pt.mode = MODE_ADD;
          pt.x_coord = near(cx, spread);
          pt.y_coord = near(cy, spread);
          send_point(pt);
          phase_items++;
        end
        n_queries = $urandom_range(1, 2);
        for (j = 0; j < n_queries; j++) begin
          pt.mode = MODE_QUERY;
          if ($urandom_range(0, 7) == 0) begin
            pt.x_coord = COORD_W'($urandom);
            pt.y_coord = COORD_W'($urandom);
          end else begin
            pt.x_coord = near(cx, 2 * spread);
            pt.y_coord = near(cy, 2 * spread);
          end
          send_point(pt);
          phase_items++;
        end
      end
    end

    // Fill the store past its capacity with one point, so a query there lands every
    // reference in the innermost bin; the extra adds must be dropped.
    write_mean_dist(MDS_W'($urandom_range(64, 65536)));
    pick_idling(2);
    pt.mode = MODE_CLEAR;
    send_point(pt);
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    pt.mode = MODE_ADD;
    pt.x_coord = COORD_W'(cx);
    pt.y_coord = COORD_W'(cy);
    for (j = 0; j < MAX_REFS + 2; j++) send_point(pt);
    pt.mode = MODE_QUERY;
    send_point(pt);
    pt.mode = MODE_ADD;
    pt.x_coord = near(cx, 64);
    pt.y_coord = near(cy, 64);
    send_point(pt);
    pt.mode = MODE_QUERY;
    send_point(pt);
    pt.mode = MODE_CLEAR;
    send_point(pt);

    drain_and_settle();
    $display("Run covered %0d accepted beats, %0d queries and %0d mean distance settings,",
             points_accepted, queries_accepted, settings_written);
    $display("including a full reference store; %0d bins compared, %0d mismatches.",
             bins_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
